// ===== design/smart_card_atr_parser_assert.svh =====
`ifndef SMART_CARD_ATR_PARSER_ASSERT_SVH
`define SMART_CARD_ATR_PARSER_ASSERT_SVH

// checked at every clock edge, reset included
`define SCAP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// checked outside reset only
`define SCAP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== design/scap_pkg.sv =====
`default_nettype none

package scap_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_T0,
    PH_IFACE,
    PH_HIST,
    PH_TCK
  } phase_t;

  typedef enum logic [2:0] {
    KIND_TS,
    KIND_T0,
    KIND_TA,
    KIND_TB,
    KIND_TC,
    KIND_TD,
    KIND_HIST,
    KIND_TCK
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_BAD_TS,
    ST_TIMEOUT,
    ST_OVERFLOW,
    ST_TA2_MODE
  } status_t;

  typedef enum logic [1:0] {
    MODE_DEFAULT,
    MODE_SPECIFIC,
    MODE_NEGOTIATE
  } mode_t;

  typedef struct packed {
    kind_t       byte_kind;
    logic [2:0]  group_index;
    logic        done_res;
    status_t     status;
    logic        check_ok;
    mode_t       rate_mode;
    logic [7:0]  rate_byte;
    logic [11:0] etu_ticks;
    logic [7:0]  atr_length;
  } scap_result_t;

  localparam logic [7:0]  TS_DIRECT         = 8'h3B;
  localparam logic [7:0]  TS_INVERSE        = 8'h3F;
  localparam logic [7:0]  TA2_SPECIFIC      = 8'h80;
  localparam logic [7:0]  RATE_DEFAULT      = 8'h11;
  localparam logic [7:0]  MAX_ATR_LEN_RESET = 8'd33;
  localparam logic [2:0]  MAX_GROUPS        = 3'd4;
  localparam logic [11:0] ETU_DEFAULT       = 12'd372;

  localparam logic [11:0] F_TABLE [16] = '{
    12'd372, 12'd372, 12'd558, 12'd744, 12'd1116, 12'd1488, 12'd1860, 12'd0,
    12'd256, 12'd512, 12'd768, 12'd1024, 12'd1536, 12'd2048, 12'd0, 12'd0
  };

  // F over D for the divisors that are not powers of two
  localparam logic [7:0] F_DIV12 [16] = '{
    8'd31, 8'd31, 8'd46, 8'd62, 8'd93, 8'd124, 8'd155, 8'd0,
    8'd21, 8'd42, 8'd64, 8'd85, 8'd128, 8'd170, 8'd0, 8'd0
  };
  localparam logic [7:0] F_DIV20 [16] = '{
    8'd18, 8'd18, 8'd27, 8'd37, 8'd55, 8'd74, 8'd93, 8'd0,
    8'd12, 8'd25, 8'd38, 8'd51, 8'd76, 8'd102, 8'd0, 8'd0
  };
  localparam logic [7:0] F_DIV372 [16] = '{
    8'd1, 8'd1, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd0,
    8'd0, 8'd1, 8'd2, 8'd2, 8'd4, 8'd5, 8'd0, 8'd0
  };

  function automatic logic [11:0] etu_of(input logic [7:0] rate);
    logic [11:0] f;
    logic [11:0] etu;
    f = F_TABLE[rate[7:4]];
    case (rate[3:0])
      4'd2:    etu = f >> 1;
      4'd3:    etu = f >> 2;
      4'd4:    etu = f >> 3;
      4'd5:    etu = f >> 4;
      4'd6:    etu = f >> 5;
      4'd7:    etu = f >> 6;
      4'd8:    etu = {4'd0, F_DIV12[rate[7:4]]};
      4'd9:    etu = {4'd0, F_DIV20[rate[7:4]]};
      4'd13:   etu = {4'd0, F_DIV372[rate[7:4]]};
      4'd14:   etu = f >> 8;
      4'd15:   etu = f >> 7;
      default: etu = f;
    endcase
    return etu;
  endfunction

endpackage

`default_nettype wire

// ===== design/smart_card_atr_parser.sv =====
// Path: a transferred byte is captured in the hold register, then parsed and
// registered in the result register once that frees, then offered from there.
// Throughput: one byte per cycle; the result register frees the input side
// whenever the result is taken or empty.
// Reset: synchronous rst empties both registers, returns the parser to idle
// and sets max_atr_len to 33.
`default_nettype none

module smart_card_atr_parser import scap_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        start_req,
  input  logic        timeout,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  byte_kind,
  output logic [2:0]  group_index,
  output logic        done_res,
  output logic [2:0]  status,
  output logic        check_ok,
  output logic [1:0]  rate_mode,
  output logic [7:0]  rate_byte,
  output logic [11:0] etu_ticks,
  output logic [7:0]  atr_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic [7:0]   max_atr_len;
  logic         hold_valid;
  logic [7:0]   hold_rx_byte;
  logic         hold_start_req;
  logic         hold_timeout;
  logic         step;
  scap_result_t res_next;
  scap_result_t res;

  assign cfg_ready = 1'b1;
  assign step      = hold_valid && (!out_valid || out_ready);
  assign in_ready  = !hold_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_atr_len <= MAX_ATR_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_atr_len <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_rx_byte   <= rx_byte;
      hold_start_req <= start_req;
      hold_timeout   <= timeout;
    end
  end

  scap_core u_core (
    .clk         (clk),
    .rst         (rst),
    .en          (step),
    .rx_byte     (hold_rx_byte),
    .start_req   (hold_start_req),
    .timeout     (hold_timeout),
    .max_atr_len (max_atr_len),
    .result      (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res <= res_next;
    end
  end

  assign byte_kind   = res.byte_kind;
  assign group_index = res.group_index;
  assign done_res    = res.done_res;
  assign status      = res.status;
  assign check_ok    = res.check_ok;
  assign rate_mode   = res.rate_mode;
  assign rate_byte   = res.rate_byte;
  assign etu_ticks   = res.etu_ticks;
  assign atr_length  = res.atr_length;

endmodule

`default_nettype wire

// ===== design/scap_core.sv =====
`default_nettype none

module scap_core import scap_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic [7:0]   rx_byte,
  input  logic         start_req,
  input  logic         timeout,
  input  logic [7:0]   max_atr_len,
  output scap_result_t result
);

  phase_t     phase, phase_next;
  logic [3:0] pending_indicators, pending_indicators_next;
  logic [2:0] group_count, group_count_next;
  logic       needs_check_byte, needs_check_byte_next;
  logic [3:0] historical_left, historical_left_next;
  logic [7:0] byte_count, byte_count_next;
  logic [7:0] xor_accumulator, xor_accumulator_next;
  logic [7:0] first_ta, first_ta_next;
  logic [7:0] second_ta, second_ta_next;

  logic [1:0] which;
  logic       ended;
  logic [7:0] rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_IDLE;
      pending_indicators <= '0;
      group_count        <= '0;
      needs_check_byte   <= 1'b0;
      historical_left    <= '0;
      byte_count         <= '0;
      xor_accumulator    <= '0;
      first_ta           <= '0;
      second_ta          <= '0;
    end else if (en) begin
      phase              <= phase_next;
      pending_indicators <= pending_indicators_next;
      group_count        <= group_count_next;
      needs_check_byte   <= needs_check_byte_next;
      historical_left    <= historical_left_next;
      byte_count         <= byte_count_next;
      xor_accumulator    <= xor_accumulator_next;
      first_ta           <= first_ta_next;
      second_ta          <= second_ta_next;
    end
  end

  always_comb begin
    if (pending_indicators[0]) begin
      which = 2'd0;
    end else if (pending_indicators[1]) begin
      which = 2'd1;
    end else if (pending_indicators[2]) begin
      which = 2'd2;
    end else begin
      which = 2'd3;
    end
  end

  always_comb begin
    phase_next              = phase;
    pending_indicators_next = pending_indicators;
    group_count_next        = group_count;
    needs_check_byte_next   = needs_check_byte;
    historical_left_next    = historical_left;
    byte_count_next         = byte_count;
    xor_accumulator_next    = xor_accumulator;
    first_ta_next           = first_ta;
    second_ta_next          = second_ta;
    ended                   = 1'b0;
    rate                    = RATE_DEFAULT;

    result           = '0;
    result.byte_kind = KIND_TS;
    result.status    = ST_OK;
    result.rate_mode = MODE_DEFAULT;

    if (timeout) begin
      if (phase != PH_IDLE) begin
        result.done_res = 1'b1;
        result.status   = ST_TIMEOUT;
      end
      phase_next = PH_IDLE;
    end else if (start_req) begin
      pending_indicators_next = '0;
      group_count_next        = '0;
      needs_check_byte_next   = 1'b0;
      historical_left_next    = '0;
      xor_accumulator_next    = '0;
      first_ta_next           = '0;
      second_ta_next          = '0;
      byte_count_next         = (max_atr_len != 8'd0) ? 8'd1 : 8'd0;
      phase_next              = PH_IDLE;
      if (rx_byte != TS_DIRECT && rx_byte != TS_INVERSE) begin
        result.done_res = 1'b1;
        result.status   = ST_BAD_TS;
      end else if (max_atr_len == 8'd0) begin
        result.done_res = 1'b1;
        result.status   = ST_OVERFLOW;
      end else begin
        phase_next = PH_T0;
      end
    end else if (phase != PH_IDLE) begin
      case (phase)
        PH_T0:   result.byte_kind = KIND_T0;
        PH_HIST: result.byte_kind = KIND_HIST;
        PH_TCK:  result.byte_kind = KIND_TCK;
        PH_IFACE: begin
          case (which)
            2'd0:    result.byte_kind = KIND_TA;
            2'd1:    result.byte_kind = KIND_TB;
            2'd2:    result.byte_kind = KIND_TC;
            default: result.byte_kind = KIND_TD;
          endcase
          result.group_index = group_count + 3'd1;
        end
        default: result.byte_kind = KIND_TS;
      endcase

      if (byte_count >= max_atr_len) begin
        result.done_res = 1'b1;
        result.status   = ST_OVERFLOW;
        phase_next      = PH_IDLE;
      end else begin
        byte_count_next      = byte_count + 8'd1;
        xor_accumulator_next = xor_accumulator ^ rx_byte;
        case (phase)
          PH_T0: begin
            pending_indicators_next = rx_byte[7:4];
            historical_left_next    = rx_byte[3:0];
          end
          PH_IFACE: begin
            pending_indicators_next = pending_indicators & ~(4'b0001 << which);
            if (which == 2'd0) begin
              if (group_count == 3'd0) begin
                first_ta_next = rx_byte;
              end else if (group_count == 3'd1) begin
                second_ta_next = rx_byte;
              end
            end else if (which == 2'd3) begin
              group_count_next = group_count + 3'd1;
              if (rx_byte[3:0] != 4'd0) begin
                needs_check_byte_next = 1'b1;
              end
              pending_indicators_next = (group_count_next >= MAX_GROUPS) ? 4'd0
                                                                         : rx_byte[7:4];
            end
          end
          PH_HIST: historical_left_next = historical_left - 4'd1;
          default: ;
        endcase

        if (phase == PH_TCK) begin
          ended = 1'b1;
        end else if (pending_indicators_next != 4'd0) begin
          phase_next = PH_IFACE;
        end else if (historical_left_next != 4'd0) begin
          phase_next = PH_HIST;
        end else if (needs_check_byte_next) begin
          phase_next = PH_TCK;
        end else begin
          ended = 1'b1;
        end
      end
    end

    if (ended) begin
      phase_next      = PH_IDLE;
      result.done_res = 1'b1;
      result.check_ok = needs_check_byte_next ? (xor_accumulator_next == 8'd0) : 1'b1;
      if (second_ta_next != 8'd0 && second_ta_next != TA2_SPECIFIC) begin
        result.status = ST_TA2_MODE;
      end else if (second_ta_next == TA2_SPECIFIC) begin
        result.rate_mode = MODE_SPECIFIC;
        rate             = first_ta_next;
      end else if (first_ta_next != RATE_DEFAULT && first_ta_next != 8'd0) begin
        result.rate_mode = MODE_NEGOTIATE;
        rate             = first_ta_next;
      end
    end

    result.rate_byte  = rate;
    result.etu_ticks  = etu_of(rate);
    result.atr_length = byte_count_next;
  end

endmodule

`default_nettype wire

// ===== design/scap_chk.sv =====
`default_nettype none
`include "smart_card_atr_parser_assert.svh"

module scap_chk import scap_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  byte_kind,
  input logic [2:0]  group_index,
  input logic        done_res,
  input logic [2:0]  status,
  input logic        check_ok,
  input logic [1:0]  rate_mode,
  input logic [7:0]  rate_byte,
  input logic [11:0] etu_ticks,
  input logic [7:0]  atr_length
);

  `SCAP_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid after reset")

  `SCAP_ASSERT(a_hold_stalled, out_valid && !out_ready |=> out_valid && $stable(byte_kind) && $stable(status) && $stable(atr_length) && $stable(etu_ticks), "stalled result changed")

  `SCAP_ASSERT(a_open_is_clean, out_valid && !done_res |-> status == ST_OK && !check_ok, "error or check flag on an open ATR")

  `SCAP_ASSERT(a_error_rate, out_valid && status != ST_OK |-> rate_mode == MODE_DEFAULT && rate_byte == RATE_DEFAULT && etu_ticks == ETU_DEFAULT, "non-default rate on a failed ATR")

  `SCAP_ASSERT(a_group_only_iface, out_valid && (byte_kind == KIND_TS || byte_kind == KIND_T0 || byte_kind == KIND_HIST || byte_kind == KIND_TCK) |-> group_index == 3'd0, "group index on a non-interface byte")

endmodule

bind smart_card_atr_parser scap_chk u_scap_chk (.*);

`default_nettype wire
